/* design/macd_pkg.sv */
package macd_pkg;

   // configured periods are 8-bit day counts
   localparam int DAYS_BITS    = 8;
   localparam int CSR_IDX_BITS = 2;

   // csr register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHORT_DAYS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_DAYS   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIGNAL_DAYS = 2'd2;

   // reset periods
   localparam logic [DAYS_BITS-1:0] SHORT_DAYS_RST  = 8'd12;
   localparam logic [DAYS_BITS-1:0] LONG_DAYS_RST   = 8'd26;
   localparam logic [DAYS_BITS-1:0] SIGNAL_DAYS_RST = 8'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRICE,
      ST_DIFF,
      ST_SIGNAL,
      ST_FINISH
   } macd_state_type;

   typedef enum logic [1:0] {
      EMA_IDLE,
      EMA_MUL,
      EMA_DIV
   } ema_phase_type;

   // start strobe plus weight (N-1) and divisor (N+1) for one average update
   typedef struct packed {
      logic                 start;
      logic [DAYS_BITS-1:0] mul;
      logic [DAYS_BITS:0]   div;
   } ema_cmd_type;

   // period 0 behaves as period 1
   function automatic ema_cmd_type ema_cmd(input logic start, input logic [DAYS_BITS-1:0] days);
      ema_cmd_type          c;
      logic [DAYS_BITS-1:0] n;
      n       = (days == '0) ? DAYS_BITS'(1) : days;
      c.start = start;
      c.mul   = n - DAYS_BITS'(1);
      c.div   = {1'b0, n} + (DAYS_BITS + 1)'(1);
      return c;
   endfunction

endpackage

/* design/macd_ema_unit.sv */
// Bit-serial EMA update: q = floor((2*x + mul*e) / div).
// MUL phase builds the numerator LSB first, DIV phase is a restoring divide MSB first.
module macd_ema_unit #(
   parameter int W = 49
) (
   input  logic                   clock,
   input  logic                   reset,
   input  macd_pkg::ema_cmd_type  cmd,
   input  logic [W-1:0]           x_in,
   input  logic [W-1:0]           e_in,
   output logic                   done,
   output logic [W-1:0]           q
);

   localparam int DB = macd_pkg::DAYS_BITS;
   localparam int NW = W + DB;            // numerator width
   localparam int CW = $clog2(NW);
   localparam int KB = 4;                 // column carry

   macd_pkg::ema_phase_type phase_ff, phase_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  e_sr_ff, e_sr_in;
   logic [W-1:0]  x_sr_ff, x_sr_in;
   logic          x_prev_ff, x_prev_in;
   logic [DB-2:0] win_ff, win_in;
   logic [KB-1:0] carry_ff, carry_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DB:0]   rem_ff, rem_in;
   logic [DB-1:0] mul_ff, mul_in;
   logic [DB:0]   div_ff, div_in;
   logic          done_ff, done_in;

   logic [DB-1:0] win_all;
   logic [KB:0]   col;
   logic [DB+1:0] trial;
   logic [DB+1:0] trial_sub;
   logic          ge;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         macd_pkg::EMA_IDLE: begin
            if (cmd.start) phase_in = macd_pkg::EMA_MUL;
         end
         macd_pkg::EMA_MUL: begin
            if (cnt_ff == '0) phase_in = macd_pkg::EMA_DIV;
         end
         macd_pkg::EMA_DIV: begin
            if (cnt_ff == '0) phase_in = macd_pkg::EMA_IDLE;
         end
         default: phase_in = macd_pkg::EMA_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      win_all   = {win_ff, e_sr_ff[0]};
      col       = (KB+1)'(carry_ff) + (KB+1)'(x_prev_ff);
      for (int k = 0; k < DB; k++) begin
         col = col + (KB+1)'(mul_ff[k] & win_all[k]);
      end
      trial     = {rem_ff, num_ff[NW-1]};
      ge        = trial >= {1'b0, div_ff};
      trial_sub = trial - {1'b0, div_ff};

      cnt_in    = cnt_ff;
      e_sr_in   = e_sr_ff;
      x_sr_in   = x_sr_ff;
      x_prev_in = x_prev_ff;
      win_in    = win_ff;
      carry_in  = carry_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      mul_in    = mul_ff;
      div_in    = div_ff;
      done_in   = 1'b0;

      unique case (phase_ff)
         macd_pkg::EMA_IDLE: begin
            if (cmd.start) begin
               e_sr_in   = e_in;
               x_sr_in   = x_in;
               x_prev_in = 1'b0;
               win_in    = '0;
               carry_in  = '0;
               mul_in    = cmd.mul;
               div_in    = cmd.div;
               cnt_in    = CW'(NW - 1);
            end
         end
         macd_pkg::EMA_MUL: begin
            // column i sums mul[k]*e[i-k] plus x[i-1] (the 2*x term) plus carry
            e_sr_in   = e_sr_ff >> 1;
            x_sr_in   = x_sr_ff >> 1;
            x_prev_in = x_sr_ff[0];
            win_in    = win_all[DB-2:0];
            carry_in  = col[KB:1];
            num_in    = {col[0], num_ff[NW-1:1]};
            cnt_in    = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               cnt_in = CW'(NW - 1);
               rem_in = '0;
            end
         end
         macd_pkg::EMA_DIV: begin
            rem_in  = ge ? trial_sub[DB:0] : trial[DB:0];
            num_in  = {num_ff[NW-2:0], ge};
            cnt_in  = cnt_ff - CW'(1);
            done_in = (cnt_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= macd_pkg::EMA_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      e_sr_ff   <= e_sr_in;
      x_sr_ff   <= x_sr_in;
      x_prev_ff <= x_prev_in;
      win_ff    <= win_in;
      carry_ff  <= carry_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      mul_ff    <= mul_in;
      div_ff    <= div_in;
   end

   assign done = done_ff;
   assign q    = num_ff[W-1:0];

endmodule

/* design/macd_ema_indicator.sv */
// Processing time per beat is set by two passes (multiply, divide) of a bit-serial EMA unit,
//   run twice in turn; a beat that starts a series skips the unit passes.
// A new beat is taken only once the previous one has loaded the response register.
// Reset (synchronous, active high): periods to 12/26/9, all averages to zero,
//   result channel empty.
module macd_ema_indicator #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write,
   input  logic [macd_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [macd_pkg::DAYS_BITS-1:0]         csr_wdata,
   // request beats
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [PRICE_BITS-1:0]                  req_price,
   input  logic                                   req_first_of_series,
   // response beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [PRICE_BITS+FRAC_BITS-1:0]        rsp_short_avg,
   output logic [PRICE_BITS+FRAC_BITS-1:0]        rsp_long_avg,
   output logic signed [PRICE_BITS+FRAC_BITS:0]   rsp_diff_value,
   output logic signed [PRICE_BITS+FRAC_BITS:0]   rsp_dea_value,
   output logic signed [PRICE_BITS+FRAC_BITS+2:0] rsp_macd_value
);

   localparam int DB        = macd_pkg::DAYS_BITS;
   localparam int AVG_BITS  = PRICE_BITS + FRAC_BITS;
   localparam int SIG_BITS  = AVG_BITS + 1;
   localparam int MACD_BITS = AVG_BITS + 3;

   // Flow per beat:
   //   IDLE   take beat; start short and long EMA units side by side
   //   PRICE  wait for both units, capture the new price averages
   //   DIFF   DIFF = short - long; start signal EMA on the shared unit
   //   SIGNAL wait for it, capture DEA
   //   FINISH form MACD and load the response register once it is free
   // A series start skips both unit passes: averages take the price, DEA takes DIFF (zero).

   macd_pkg::macd_state_type state_ff, state_in;

   logic [DB-1:0]       cfg_short_ff, cfg_short_in;
   logic [DB-1:0]       cfg_long_ff, cfg_long_in;
   logic [DB-1:0]       cfg_signal_ff, cfg_signal_in;

   logic [AVG_BITS-1:0] short_ff, short_in;
   logic [AVG_BITS-1:0] long_ff, long_in;
   logic [SIG_BITS-1:0] dea_ff, dea_in;
   logic [SIG_BITS-1:0] diff_ff, diff_in;
   logic                first_ff, first_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AVG_BITS-1:0]  rsp_short_ff, rsp_short_in;
   logic [AVG_BITS-1:0]  rsp_long_ff, rsp_long_in;
   logic [SIG_BITS-1:0]  rsp_diff_ff, rsp_diff_in;
   logic [SIG_BITS-1:0]  rsp_dea_ff, rsp_dea_in;
   logic [MACD_BITS-1:0] rsp_macd_ff, rsp_macd_in;

   logic                  accept;
   logic                  load;
   logic [SIG_BITS-1:0]   x_price;
   logic [SIG_BITS-1:0]   diff_w;
   logic [MACD_BITS-1:0]  diff_ext;
   logic [MACD_BITS-1:0]  dea_ext;

   macd_pkg::ema_cmd_type cmd_a, cmd_b;
   logic [SIG_BITS-1:0]   x_a, e_a, q_a;
   logic [SIG_BITS-1:0]   q_b;
   logic                  done_a, done_b;

   assign accept  = req_valid && !req_stall;
   assign load    = (state_ff == macd_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign x_price = SIG_BITS'(req_price) << FRAC_BITS;
   assign diff_w  = {1'b0, short_ff} - {1'b0, long_ff};
   assign diff_ext = {{2{diff_ff[SIG_BITS-1]}}, diff_ff};
   assign dea_ext  = {{2{dea_ff[SIG_BITS-1]}}, dea_ff};

   // Unit A is shared: short EMA first, then the signal EMA.
   // DEA runs biased by 2^AVG_BITS so the divide sees unsigned operands; in
   // SIG_BITS that bias is just the top bit inverted, and it comes out unchanged.
   always_comb begin
      if (state_ff == macd_pkg::ST_IDLE) begin
         cmd_a = macd_pkg::ema_cmd(accept && !req_first_of_series, cfg_short_ff);
         x_a   = x_price;
         e_a   = {1'b0, short_ff};
      end else begin
         cmd_a = macd_pkg::ema_cmd((state_ff == macd_pkg::ST_DIFF) && !first_ff, cfg_signal_ff);
         x_a   = {~diff_w[SIG_BITS-1], diff_w[SIG_BITS-2:0]};
         e_a   = {~dea_ff[SIG_BITS-1], dea_ff[SIG_BITS-2:0]};
      end
      cmd_b = macd_pkg::ema_cmd(accept && !req_first_of_series, cfg_long_ff);
   end

   macd_ema_unit #(
      .W (SIG_BITS)
   ) u_ema_a (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_a),
      .x_in  (x_a),
      .e_in  (e_a),
      .done  (done_a),
      .q     (q_a)
   );

   macd_ema_unit #(
      .W (SIG_BITS)
   ) u_ema_b (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_b),
      .x_in  (x_price),
      .e_in  ({1'b0, long_ff}),
      .done  (done_b),
      .q     (q_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         macd_pkg::ST_IDLE: begin
            if (accept) state_in = req_first_of_series ? macd_pkg::ST_DIFF : macd_pkg::ST_PRICE;
         end
         macd_pkg::ST_PRICE: begin
            if (done_a && done_b) state_in = macd_pkg::ST_DIFF;
         end
         macd_pkg::ST_DIFF: begin
            state_in = first_ff ? macd_pkg::ST_FINISH : macd_pkg::ST_SIGNAL;
         end
         macd_pkg::ST_SIGNAL: begin
            if (done_a) state_in = macd_pkg::ST_FINISH;
         end
         macd_pkg::ST_FINISH: begin
            if (load) state_in = macd_pkg::ST_IDLE;
         end
         default: state_in = macd_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      short_in     = short_ff;
      long_in      = long_ff;
      dea_in       = dea_ff;
      diff_in      = diff_ff;
      first_in     = first_ff;
      rsp_short_in = rsp_short_ff;
      rsp_long_in  = rsp_long_ff;
      rsp_diff_in  = rsp_diff_ff;
      rsp_dea_in   = rsp_dea_ff;
      rsp_macd_in  = rsp_macd_ff;

      unique case (state_ff)
         macd_pkg::ST_IDLE: begin
            if (accept) begin
               first_in = req_first_of_series;
               if (req_first_of_series) begin
                  short_in = x_price[AVG_BITS-1:0];
                  long_in  = x_price[AVG_BITS-1:0];
               end
            end
         end
         macd_pkg::ST_PRICE: begin
            if (done_a && done_b) begin
               short_in = q_a[AVG_BITS-1:0];
               long_in  = q_b[AVG_BITS-1:0];
            end
         end
         macd_pkg::ST_DIFF: begin
            diff_in = diff_w;
            if (first_ff) dea_in = diff_w;
         end
         macd_pkg::ST_SIGNAL: begin
            if (done_a) dea_in = {~q_a[SIG_BITS-1], q_a[SIG_BITS-2:0]};
         end
         macd_pkg::ST_FINISH: begin
            if (load) begin
               rsp_short_in = short_ff;
               rsp_long_in  = long_ff;
               rsp_diff_in  = diff_ff;
               rsp_dea_in   = dea_ff;
               rsp_macd_in  = (diff_ext - dea_ext) << 1;
            end
         end
         default: ;
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // csr writes; indexes past the list are dropped
   always_comb begin
      cfg_short_in  = cfg_short_ff;
      cfg_long_in   = cfg_long_ff;
      cfg_signal_in = cfg_signal_ff;
      if (csr_write) begin
         unique case (csr_index)
            macd_pkg::CSR_SHORT_DAYS:  cfg_short_in  = csr_wdata;
            macd_pkg::CSR_LONG_DAYS:   cfg_long_in   = csr_wdata;
            macd_pkg::CSR_SIGNAL_DAYS: cfg_signal_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= macd_pkg::ST_IDLE;
         cfg_short_ff  <= macd_pkg::SHORT_DAYS_RST;
         cfg_long_ff   <= macd_pkg::LONG_DAYS_RST;
         cfg_signal_ff <= macd_pkg::SIGNAL_DAYS_RST;
         short_ff      <= '0;
         long_ff       <= '0;
         dea_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_short_ff  <= cfg_short_in;
         cfg_long_ff   <= cfg_long_in;
         cfg_signal_ff <= cfg_signal_in;
         short_ff      <= short_in;
         long_ff       <= long_in;
         dea_ff        <= dea_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      diff_ff      <= diff_in;
      first_ff     <= first_in;
      rsp_short_ff <= rsp_short_in;
      rsp_long_ff  <= rsp_long_in;
      rsp_diff_ff  <= rsp_diff_in;
      rsp_dea_ff   <= rsp_dea_in;
      rsp_macd_ff  <= rsp_macd_in;
   end

   // one beat in flight at a time
   assign req_stall      = (state_ff != macd_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_short_avg  = rsp_short_ff;
   assign rsp_long_avg   = rsp_long_ff;
   assign rsp_diff_value = rsp_diff_ff;
   assign rsp_dea_value  = rsp_dea_ff;
   assign rsp_macd_value = rsp_macd_ff;

endmodule

/* design/macd_chk.sv */
module macd_chk #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_first_of_series,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [PRICE_BITS+FRAC_BITS-1:0]        rsp_short_avg,
   input logic [PRICE_BITS+FRAC_BITS-1:0]        rsp_long_avg,
   input logic signed [PRICE_BITS+FRAC_BITS:0]   rsp_diff_value,
   input logic signed [PRICE_BITS+FRAC_BITS:0]   rsp_dea_value,
   input logic signed [PRICE_BITS+FRAC_BITS+2:0] rsp_macd_value
);

   localparam int AVG_BITS  = PRICE_BITS + FRAC_BITS;
   localparam int SIG_BITS  = AVG_BITS + 1;
   localparam int MACD_BITS = AVG_BITS + 3;

   logic                 req_beat;
   logic [SIG_BITS-1:0]  diff_chk;
   logic [MACD_BITS-1:0] macd_chk_w;

   assign req_beat   = req_valid && !req_stall;
   assign diff_chk   = {1'b0, rsp_short_avg} - {1'b0, rsp_long_avg};
   assign macd_chk_w = ({{2{rsp_diff_value[SIG_BITS-1]}}, rsp_diff_value}
                       - {{2{rsp_dea_value[SIG_BITS-1]}}, rsp_dea_value}) << 1;

   // reset leaves the block empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not empty after reset");

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_macd_value)
                                   && $stable(rsp_short_avg)))
      else $error("stalled response beat changed");

   // a beat in work blocks the next one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request taken while a beat is in work");

   // series start with an empty output: flat averages reach the response via DIFF and FINISH
   a_series_seed: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_first_of_series && !rsp_valid) |-> ##3
         (rsp_valid && (rsp_short_avg == rsp_long_avg) && (rsp_diff_value == '0)
          && (rsp_dea_value == '0) && (rsp_macd_value == '0)))
      else $error("series start did not seed the averages");

   // new response is self-consistent
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ((diff_chk == rsp_diff_value) && (macd_chk_w == rsp_macd_value)))
      else $error("response fields disagree");

endmodule

bind macd_ema_indicator macd_chk #(
   .PRICE_BITS (PRICE_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_macd_chk (.*);
